>>> rtl/pc_pkg.sv
// Shared types and constants of the path canonicalizer.
package pc_pkg;

  localparam int CHAR_W  = 8;
  localparam int DEPTH_W = 5;

  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NAME_LONG  = 2'd1,
    ST_NOT_ROOTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    M_SLASH  = 2'd0,
    M_DOT    = 2'd1,
    M_DOTDOT = 2'd2,
    M_NAME   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_CNT,
    E_CNT_W,
    E_ROOT,
    E_LEN_RD,
    E_LEN_W,
    E_CHR_RD,
    E_CHR_W,
    E_SLASH,
    E_HOLD
  } emit_state_t;

  typedef struct packed {
    logic    start;
    status_t status;
  } run_cmd_t;

endpackage

>>> rtl/pc_store.sv
// Name and length memories of the directory stack, with registered reads.
module pc_store #(
  parameter int STACK_DEPTH = 16,
  parameter int NAME_CHARS  = 16
) (
  input  logic                      clk,
  input  logic                      name_we,
  input  logic [$clog2(STACK_DEPTH)-1:0] name_wrow,
  input  logic [$clog2(NAME_CHARS)-1:0]  name_wcol,
  input  logic [pc_pkg::CHAR_W-1:0] name_wdata,
  input  logic                      len_we,
  input  logic [$clog2(STACK_DEPTH)-1:0] len_waddr,
  input  logic [$clog2(NAME_CHARS)-1:0]  len_wdata,
  input  logic [$clog2(STACK_DEPTH)-1:0] rd_row,
  input  logic [$clog2(NAME_CHARS)-1:0]  rd_col,
  output logic [pc_pkg::CHAR_W-1:0] name_rdata,
  output logic [$clog2(NAME_CHARS)-1:0]  len_rdata
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int NW = $clog2(NAME_CHARS);
  localparam int NAME_ENTRIES = 2 ** (SW + NW);

  logic [pc_pkg::CHAR_W-1:0] name_mem [NAME_ENTRIES];
  logic [NW-1:0]             len_mem  [STACK_DEPTH];

  // Writes come only from the parser outside an output run, and the read data is
  // used only during a run, so a write never meets a read that is in use.
  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[{name_wrow, name_wcol}] <= name_wdata;
    end
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    name_rdata <= name_mem[{rd_row, rd_col}];
    len_rdata  <= len_mem[rd_row];
  end

endmodule

>>> rtl/pc_parse.sv
// Character parser: slash/dot state machine, stack pointer and memory writes.
module pc_parse #(
  parameter int STACK_DEPTH = 16,
  parameter int NAME_CHARS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pc_pkg::CHAR_W-1:0] ch,
  input  logic                      first,
  input  logic                      last,
  input  logic                      run_done,
  output pc_pkg::run_cmd_t          cmd,
  output logic [$clog2(STACK_DEPTH):0]   top,
  output logic                      name_we,
  output logic [$clog2(STACK_DEPTH)-1:0] name_wrow,
  output logic [$clog2(NAME_CHARS)-1:0]  name_wcol,
  output logic [pc_pkg::CHAR_W-1:0] name_wdata,
  output logic                      len_we,
  output logic [$clog2(STACK_DEPTH)-1:0] len_waddr,
  output logic [$clog2(NAME_CHARS)-1:0]  len_wdata
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int NW = $clog2(NAME_CHARS);
  localparam int TW = SW + 1;

  pc_pkg::mode_t mode, mode_next, mode_a, mode_b;
  logic [NW-1:0] plen, plen_next, plen_a, plen_b, push_len;
  logic          err, err_next, err_a, err_b;
  logic [TW-1:0] top_next, top_a;
  logic          rooted, rooted_next, rooted_a;
  logic          busy, busy_next;
  logic          do_push, do_pop, do_app, accept;
  pc_pkg::run_cmd_t cmd_next;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // command start
    mode_a   = mode;
    plen_a   = plen;
    err_a    = err;
    top_a    = top;
    rooted_a = rooted;
    if (first) begin
      mode_a = pc_pkg::M_SLASH;
      plen_a = '0;
      err_a  = 1'b0;
      if (ch == pc_pkg::CH_SLASH) begin
        top_a    = TW'(1);
        rooted_a = 1'b1;
      end
    end

    // one character
    mode_b  = mode_a;
    plen_b  = plen_a;
    err_b   = err_a;
    do_push = 1'b0;
    do_pop  = 1'b0;
    do_app  = 1'b0;
    if (!err_a) begin
      if (ch == pc_pkg::CH_SLASH) begin
        do_pop  = (mode_a == pc_pkg::M_DOTDOT);
        do_push = (mode_a == pc_pkg::M_NAME);
        mode_b  = pc_pkg::M_SLASH;
        plen_b  = '0;
      end else begin
        if (ch == pc_pkg::CH_DOT) begin
          case (mode_a)
            pc_pkg::M_SLASH: mode_b = pc_pkg::M_DOT;
            pc_pkg::M_DOT:   mode_b = pc_pkg::M_DOTDOT;
            default:         mode_b = pc_pkg::M_NAME;
          endcase
        end else begin
          mode_b = pc_pkg::M_NAME;
        end
        if (plen_a >= NW'(NAME_CHARS - 1)) begin
          err_b = 1'b1;
        end else begin
          do_app = 1'b1;
          plen_b = plen_a + NW'(1);
        end
      end
    end

    // close a trailing component on the last character
    if (last && !err_b) begin
      if (mode_b == pc_pkg::M_NAME) begin
        do_push = 1'b1;
      end
      if (mode_b == pc_pkg::M_DOTDOT) begin
        do_pop = 1'b1;
      end
    end
    push_len = (ch == pc_pkg::CH_SLASH) ? plen_a : plen_b;

    top_next    = top_a;
    rooted_next = rooted_a;
    len_we      = 1'b0;
    if (do_push && push_len != '0 && top_a < TW'(STACK_DEPTH)) begin
      len_we   = accept;
      top_next = top_a + TW'(1);
      if (top_a == '0) begin
        rooted_next = 1'b0;
      end
    end else if (do_pop && top_a > TW'(1)) begin
      top_next = top_a - TW'(1);
    end
    len_waddr = top_a[SW-1:0];
    len_wdata = push_len;

    // pending name characters live in the row just above the stack
    name_we    = accept && do_app && (top_a < TW'(STACK_DEPTH));
    name_wrow  = top_a[SW-1:0];
    name_wcol  = plen_a;
    name_wdata = ch;

    cmd_next.start  = 1'b0;
    cmd_next.status = pc_pkg::ST_OK;
    if (err_b) begin
      cmd_next.status = pc_pkg::ST_NAME_LONG;
    end else if (top_next == '0 || !rooted_next) begin
      cmd_next.status = pc_pkg::ST_NOT_ROOTED;
    end

    mode_next = mode_b;
    plen_next = plen_b;
    err_next  = err_b;
    busy_next = busy;
    if (last) begin
      mode_next      = pc_pkg::M_SLASH;
      plen_next      = '0;
      err_next       = 1'b0;
      busy_next      = 1'b1;
      cmd_next.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= pc_pkg::M_SLASH;
      plen       <= '0;
      err        <= 1'b0;
      top        <= '0;
      rooted     <= 1'b0;
      busy       <= 1'b0;
      cmd.start  <= 1'b0;
      cmd.status <= pc_pkg::ST_OK;
    end else begin
      cmd.start <= accept && cmd_next.start;
      if (accept) begin
        mode       <= mode_next;
        plen       <= plen_next;
        err        <= err_next;
        top        <= top_next;
        rooted     <= rooted_next;
        busy       <= busy_next;
        cmd.status <= cmd_next.status;
      end else if (run_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/pc_emit.sv
// Output sequencer: gives a status result, or sizes the canonical path and then walks the stack memories.
module pc_emit #(
  parameter int STACK_DEPTH = 16,
  parameter int NAME_CHARS  = 16,
  parameter int PATH_CHARS  = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pc_pkg::run_cmd_t          cmd,
  input  logic [$clog2(STACK_DEPTH):0]   top,
  output logic [$clog2(STACK_DEPTH)-1:0] rd_row,
  output logic [$clog2(NAME_CHARS)-1:0]  rd_col,
  input  logic [pc_pkg::CHAR_W-1:0] name_rdata,
  input  logic [$clog2(NAME_CHARS)-1:0]  len_rdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pc_pkg::CHAR_W-1:0] out_char,
  output pc_pkg::status_t           status,
  output logic                      end_of_run,
  output logic                      run_done
);

  localparam int SW   = $clog2(STACK_DEPTH);
  localparam int NW   = $clog2(NAME_CHARS);
  localparam int TW   = SW + 1;
  localparam int CW   = $clog2(PATH_CHARS);
  localparam int SUMW = ((CW > NW) ? CW : NW) + 1;

  pc_pkg::emit_state_t state, state_next;

  logic [TW-1:0]   idx;
  logic [NW-1:0]   k;
  logic [NW-1:0]   len;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   n;
  logic [CW-1:0]   r;
  logic            after_slash;
  logic [SUMW-1:0] sum;
  logic            sum_full;
  logic            cnt_end;
  logic            last_pos;

  assign sum      = SUMW'(cnt) + SUMW'(len_rdata);
  assign sum_full = (sum >= SUMW'(PATH_CHARS - 1));
  assign cnt_end  = (idx >= top) || (cnt == CW'(PATH_CHARS - 1));
  assign last_pos = (r == n - CW'(1));

  always_comb begin
    state_next = state;
    case (state)
      pc_pkg::E_IDLE: begin
        if (cmd.start) begin
          state_next = (cmd.status != pc_pkg::ST_OK) ? pc_pkg::E_HOLD : pc_pkg::E_CNT;
        end
      end
      pc_pkg::E_CNT:    state_next = cnt_end ? pc_pkg::E_ROOT : pc_pkg::E_CNT_W;
      pc_pkg::E_CNT_W:  state_next = sum_full ? pc_pkg::E_ROOT : pc_pkg::E_CNT;
      pc_pkg::E_ROOT:   state_next = pc_pkg::E_HOLD;
      pc_pkg::E_LEN_RD: state_next = pc_pkg::E_LEN_W;
      pc_pkg::E_LEN_W:  state_next = pc_pkg::E_CHR_RD;
      pc_pkg::E_CHR_RD: state_next = pc_pkg::E_CHR_W;
      pc_pkg::E_CHR_W:  state_next = pc_pkg::E_HOLD;
      pc_pkg::E_SLASH:  state_next = pc_pkg::E_HOLD;
      pc_pkg::E_HOLD: begin
        if (out_ready) begin
          if (end_of_run) begin
            state_next = pc_pkg::E_IDLE;
          end else if (after_slash) begin
            state_next = pc_pkg::E_LEN_RD;
          end else if (k != len) begin
            state_next = pc_pkg::E_CHR_RD;
          end else begin
            state_next = pc_pkg::E_SLASH;
          end
        end
      end
      default: state_next = pc_pkg::E_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state == pc_pkg::E_HOLD);
    run_done  = (state == pc_pkg::E_HOLD) && out_ready && end_of_run;
    rd_row    = idx[SW-1:0];
    rd_col    = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pc_pkg::E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pc_pkg::E_IDLE: begin
        if (cmd.start) begin
          idx <= TW'(1);
          cnt <= CW'(1);
          if (cmd.status != pc_pkg::ST_OK) begin
            out_char   <= pc_pkg::CH_NONE;
            status     <= cmd.status;
            end_of_run <= 1'b1;
          end
        end
      end
      pc_pkg::E_CNT: begin
        // a full buffer or a finished walk ends on a slash; drop it
        if (cnt_end) begin
          n <= (cnt > CW'(1)) ? cnt - CW'(1) : cnt;
        end
      end
      pc_pkg::E_CNT_W: begin
        if (sum_full) begin
          n <= CW'(PATH_CHARS - 1);
        end else begin
          cnt <= CW'(sum + SUMW'(1));
          idx <= idx + TW'(1);
        end
      end
      pc_pkg::E_ROOT: begin
        out_char    <= pc_pkg::CH_SLASH;
        status      <= pc_pkg::ST_OK;
        end_of_run  <= (n == CW'(1));
        r           <= '0;
        idx         <= TW'(1);
        after_slash <= 1'b1;
      end
      pc_pkg::E_LEN_W: begin
        len <= len_rdata;
        k   <= '0;
      end
      pc_pkg::E_CHR_W: begin
        out_char    <= name_rdata;
        end_of_run  <= last_pos;
        k           <= k + NW'(1);
        after_slash <= 1'b0;
      end
      pc_pkg::E_SLASH: begin
        out_char    <= pc_pkg::CH_SLASH;
        end_of_run  <= last_pos;
        idx         <= idx + TW'(1);
        after_slash <= 1'b1;
      end
      pc_pkg::E_HOLD: begin
        if (out_ready && !end_of_run) begin
          r <= r + CW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/path_canonicalizer_top.sv
// Top level of the path canonicalizer: parser, stack memories, output sequencer.
//
// Input channel (in_valid/in_ready, ch/first/last) takes one path character per
// transaction. Ordinary characters are taken one per cycle; first marks the start
// of a command, last closes it and starts an output run. While a run is under
// way in_ready stays low.
// Output channel (out_valid/out_ready) gives the canonical path one character
// per transaction, with end_of_run on the final one, or a single status
// transaction (out_char zero) when a name was too long or the stack is unrooted.
// A status result goes from the registered command straight into the output
// register. A path run first sizes the path by walking the stack entries, then
// emits the root slash, and per name reads its length, then each name character
// and then a separator, each output waiting for the output handshake. The name
// memory has a registered read that feeds a single output register.
// Reset empties the stack (unrooted), clears the parser and needs no memory
// sweep. When the receiver stalls the current result holds in the output
// register and the sequencer waits.
module path_canonicalizer_top #(
  parameter int STACK_DEPTH = 16,
  parameter int NAME_CHARS  = 16,
  parameter int PATH_CHARS  = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pc_pkg::CHAR_W-1:0] ch,
  input  logic                      first,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pc_pkg::CHAR_W-1:0] out_char,
  output logic [1:0]                status,
  output logic [pc_pkg::DEPTH_W-1:0] depth,
  output logic                      end_of_run
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int NW = $clog2(NAME_CHARS);
  localparam int TW = SW + 1;

  pc_pkg::run_cmd_t          cmd;
  pc_pkg::status_t           status_e;
  logic [TW-1:0]             top;
  logic [TW+pc_pkg::DEPTH_W-1:0] top_ext;
  logic                      run_done;
  logic                      name_we;
  logic [SW-1:0]             name_wrow;
  logic [NW-1:0]             name_wcol;
  logic [pc_pkg::CHAR_W-1:0] name_wdata;
  logic                      len_we;
  logic [SW-1:0]             len_waddr;
  logic [NW-1:0]             len_wdata;
  logic [SW-1:0]             rd_row;
  logic [NW-1:0]             rd_col;
  logic [pc_pkg::CHAR_W-1:0] name_rdata;
  logic [NW-1:0]             len_rdata;

  pc_parse #(
    .STACK_DEPTH(STACK_DEPTH),
    .NAME_CHARS (NAME_CHARS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .first     (first),
    .last      (last),
    .run_done  (run_done),
    .cmd       (cmd),
    .top       (top),
    .name_we   (name_we),
    .name_wrow (name_wrow),
    .name_wcol (name_wcol),
    .name_wdata(name_wdata),
    .len_we    (len_we),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata)
  );

  pc_store #(
    .STACK_DEPTH(STACK_DEPTH),
    .NAME_CHARS (NAME_CHARS)
  ) u_store (
    .clk       (clk),
    .name_we   (name_we),
    .name_wrow (name_wrow),
    .name_wcol (name_wcol),
    .name_wdata(name_wdata),
    .len_we    (len_we),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .name_rdata(name_rdata),
    .len_rdata (len_rdata)
  );

  pc_emit #(
    .STACK_DEPTH(STACK_DEPTH),
    .NAME_CHARS (NAME_CHARS),
    .PATH_CHARS (PATH_CHARS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .top       (top),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .name_rdata(name_rdata),
    .len_rdata (len_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .status    (status_e),
    .end_of_run(end_of_run),
    .run_done  (run_done)
  );

  assign status  = status_e;
  assign top_ext = {{pc_pkg::DEPTH_W{1'b0}}, top};
  assign depth   = top_ext[pc_pkg::DEPTH_W-1:0];

endmodule

>>> test/tb_path_canonicalizer_top.sv
// Testbench for the path canonicalizer: directed and random commands, results checked per character.
`timescale 1ns / 1ps

module tb_path_canonicalizer_top;

  localparam int CHAR_W       = pc_pkg::CHAR_W;
  localparam int DEPTH_W      = pc_pkg::DEPTH_W;
  localparam int STACK_DEPTH  = 16;
  localparam int NAME_CHARS   = 16;
  localparam int PATH_CHARS   = 64;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 30;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t char_q_t[$];

  typedef struct {
    char_t              chr;
    pc_pkg::status_t    st;
    logic [DEPTH_W-1:0] dep;
    logic               eor;
  } path_result_t;

  // Tracks the directory stack and queues the result characters each command produces.
  class path_scoreboard;
    pc_pkg::mode_t parse_state;
    char_t         name_buf[NAME_CHARS];
    int unsigned   name_len;
    char_t         dir_names[STACK_DEPTH][NAME_CHARS];
    int unsigned   dir_lens[STACK_DEPTH];
    int unsigned   dir_top;
    bit            too_long;
    path_result_t  due_results[$];
    int            errors;

    function new();
      parse_state = pc_pkg::M_SLASH;
      name_len    = 0;
      dir_top     = 0;
      too_long    = 1'b0;
      errors      = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void push_name();
      if (name_len == 0 || dir_top >= STACK_DEPTH) return;
      for (int k = 0; k < name_len; k++) dir_names[dir_top][k] = name_buf[k];
      dir_lens[dir_top] = name_len;
      dir_top++;
    endfunction

    function void pop_dir();
      if (dir_top > 1) dir_top--;
    endfunction

    function void add_char(char_t c);
      if (name_len + 1 >= NAME_CHARS) begin
        too_long = 1'b1;
      end else begin
        name_buf[name_len] = c;
        name_len++;
      end
    endfunction

    function void note_char(char_t c, logic f, logic l);
      char_t        path[$];
      path_result_t r;
      if (f) begin
        parse_state = pc_pkg::M_SLASH;
        name_len    = 0;
        too_long    = 1'b0;
        if (c == pc_pkg::CH_SLASH) begin
          dir_names[0][0] = pc_pkg::CH_SLASH;
          dir_lens[0]     = 1;
          dir_top         = 1;
        end
      end
      if (!too_long) begin
        if (c == pc_pkg::CH_SLASH) begin
          if (parse_state == pc_pkg::M_DOTDOT) pop_dir();
          else if (parse_state == pc_pkg::M_NAME) push_name();
          parse_state = pc_pkg::M_SLASH;
          name_len    = 0;
        end else begin
          if (c != pc_pkg::CH_DOT) parse_state = pc_pkg::M_NAME;
          else if (parse_state == pc_pkg::M_SLASH) parse_state = pc_pkg::M_DOT;
          else if (parse_state == pc_pkg::M_DOT) parse_state = pc_pkg::M_DOTDOT;
          else parse_state = pc_pkg::M_NAME;
          add_char(c);
        end
      end
      if (!l) return;

      // close the trailing component
      if (!too_long) begin
        if (parse_state == pc_pkg::M_NAME) push_name();
        else if (parse_state == pc_pkg::M_DOTDOT) pop_dir();
      end
      parse_state = pc_pkg::M_SLASH;
      name_len    = 0;

      r.chr = pc_pkg::CH_NONE;
      r.dep = DEPTH_W'(dir_top);
      r.eor = 1'b1;
      if (too_long) begin
        too_long = 1'b0;
        r.st     = pc_pkg::ST_NAME_LONG;
        due_results.push_back(r);
        return;
      end
      if (dir_top == 0 || dir_lens[0] != 1 || dir_names[0][0] != pc_pkg::CH_SLASH) begin
        r.st = pc_pkg::ST_NOT_ROOTED;
        due_results.push_back(r);
        return;
      end

      path.push_back(pc_pkg::CH_SLASH);
      for (int i = 1; i < dir_top; i++) begin
        for (int k = 0; k < dir_lens[i]; k++)
          if (path.size() < PATH_CHARS - 1) path.push_back(dir_names[i][k]);
        if (path.size() < PATH_CHARS - 1) path.push_back(pc_pkg::CH_SLASH);
      end
      if (path.size() > 1 && path[path.size() - 1] == pc_pkg::CH_SLASH)
        void'(path.pop_back());
      r.st = pc_pkg::ST_OK;
      foreach (path[i]) begin
        r.chr = path[i];
        r.eor = (i == path.size() - 1);
        due_results.push_back(r);
      end
    endfunction

    function void check_result(char_t c, logic [1:0] st, logic [DEPTH_W-1:0] d, logic e);
      path_result_t w;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result char %02h status %0d depth %0d end %0b",
                 $time, c, st, d, e);
        return;
      end
      w = due_results.pop_front();
      if (c !== w.chr || st !== w.st || d !== w.dep || e !== w.eor) begin
        errors++;
        $display("%0t: expected char %02h status %0d depth %0d end %0b, %s %02h %0d %0d %0b",
                 $time, w.chr, w.st, w.dep, w.eor, "actual", c, st, d, e);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  char_t              ch = 8'h01;
  logic               first = 1'b0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  char_t              out_char;
  logic [1:0]         status;
  logic [DEPTH_W-1:0] depth;
  logic               end_of_run;

  path_scoreboard sb;
  int send_idle_pct = 20;
  int recv_idle_pct = 76;
  int stall_cycles = 0;

  path_canonicalizer_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .first      (first),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .status     (status),
    .depth      (depth),
    .end_of_run (end_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check results, note accepted characters, and bail out on a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_char, status, depth, end_of_run);
      if (in_valid && in_ready) sb.note_char(ch, first, last);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Called and returns at a falling edge.
  task automatic send_char(char_t c, bit f, bit l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    first    <= f;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_bytes(char_q_t q, bit with_first);
    foreach (q[i]) send_char(q[i], with_first && i == 0, i == q.size() - 1);
  endtask

  task automatic send_path(string s, bit with_first);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q, with_first);
  endtask

  // Hold the input until every due result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic char_q_t random_path();
    char_q_t q;
    int      parts;
    int      sel;
    int      len;
    parts = $urandom_range(0, 5);
    if ($urandom_range(99) < 75) q.push_back(pc_pkg::CH_SLASH);
    for (int p = 0; p < parts; p++) begin
      if (p > 0) begin
        len = ($urandom_range(99) < 80) ? 1 : $urandom_range(2, 3);
        repeat (len) q.push_back(pc_pkg::CH_SLASH);
      end
      sel = $urandom_range(99);
      if (sel < 10) begin
        q.push_back(pc_pkg::CH_DOT);
      end else if (sel < 22) begin
        q.push_back(pc_pkg::CH_DOT);
        q.push_back(pc_pkg::CH_DOT);
      end else if (sel < 27) begin
        repeat ($urandom_range(3, 4)) q.push_back(pc_pkg::CH_DOT);
      end else begin
        len = (sel < 34) ? $urandom_range(14, 17) : $urandom_range(1, 5);
        repeat (len) begin
          if ($urandom_range(99) < 70) q.push_back(char_t'($urandom_range(8'h61, 8'h7A)));
          else q.push_back(char_t'($urandom_range(1, 255)));
        end
      end
    end
    if (q.size() == 0 || $urandom_range(99) < 20) begin
      if (q.size() == 0) q.push_back(char_t'($urandom_range(1, 255)));
      else q.push_back(pc_pkg::CH_SLASH);
    end
    return q;
  endfunction

  // Mostly well-formed commands, some without a first mark, some loose characters.
  task automatic random_burst(int n_items);
    int      sent;
    char_q_t q;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        q = random_path();
        send_bytes(q, $urandom_range(99) < 92);
        sent += q.size();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_char(char_t'($urandom_range(1, 255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    char_q_t q;
    sb = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed commands
    send_path("x", 1'b1);
    send_path("..", 1'b1);
    send_path("/", 1'b1);
    send_path(".", 1'b1);
    send_path("//usr///bin/", 1'b1);
    send_path("/a/./b/.", 1'b1);
    send_path("/a/b/..", 1'b1);
    send_path("/../..", 1'b1);
    send_path("/.../.a/a./..x", 1'b1);
    send_path("c/d", 1'b1);
    send_path("e", 1'b0);
    send_path("/abcdefghijklmno", 1'b1);
    send_path("/q/abcdefghijklmnop/more", 1'b1);
    send_path("z", 1'b1);
    send_path({"/", "....", "....", "....", "...."}, 1'b1);
    q.push_back(pc_pkg::CH_SLASH);
    q.push_back(8'h01);
    q.push_back(8'hFF);
    q.push_back(8'h80);
    q.push_back(8'h7F);
    q.push_back(pc_pkg::CH_SLASH);
    q.push_back(8'hFE);
    send_bytes(q, 1'b1);
    send_path("/1/2/3/4/5/6/7/8/9/a/b/c/d/e/f/g/h", 1'b1);
    send_path("../x", 1'b1);
    send_path({"/ABCDEFGHIJKLMNO/abcdefghijklmno/PQRSTUVWXYZ0123", "/klmnopqrstuvw/z"}, 1'b1);
    send_path("../../abcdefghijklmn", 1'b1);

    random_burst(RANDOM_ITEMS / 3);
    drain();
    send_idle_pct = 76;
    recv_idle_pct = 20;
    random_burst(RANDOM_ITEMS / 3);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(RANDOM_ITEMS / 3);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pc_pkg.sv
rtl/pc_store.sv
rtl/pc_parse.sv
rtl/pc_emit.sv
rtl/path_canonicalizer_top.sv
test/tb_path_canonicalizer_top.sv
